FILE: sv/rrl_pkg.sv
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared constants and helpers for the radial ripple LED pattern block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrl_pkg;

  localparam int TIME_W     = 48;
  localparam int DUR_W      = 24;
  localparam int WWS_W      = 8;
  localparam int PEAK_W     = 8;
  localparam int PIX_W      = 6;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_PIXELS = 64;

  localparam int DEF_GRID_WIDTH  = 8;
  localparam int DEF_GRID_HEIGHT = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_W   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK     = 2'd2;

  localparam logic [DUR_W-1:0]  RST_DURATION = 24'd3000000;
  localparam logic [WWS_W-1:0]  RST_WAVE_W   = 8'd40;
  localparam logic [PEAK_W-1:0] RST_PEAK     = 8'd100;

  // floor square root, elaboration time only
  function automatic int rrl_isqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return int'(root);
  endfunction

endpackage

`default_nettype wire

FILE: sv/rrl_sqrt.sv
// ----------------------------------------------------------------------------
// rrl_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrl_sqrt #(
  parameter int RW = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] opnd,
  output logic                 done,
  output logic [RW-1:0]        root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] a;
  logic [RW:0]     r;
  logic [CW-1:0]   cnt;
  logic            running;
  logic [RW+2:0]   rt;
  logic [RW+2:0]   t;

  assign rt = {r, a[2*RW-1:2*RW-2]};
  assign t  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a       <= opnd;
        r       <= '0;
        root    <= '0;
        cnt     <= CW'(RW);
        running <= 1'b1;
      end else if (running) begin
        a <= {a[2*RW-3:0], 2'b00};
        if (rt >= t) begin
          r    <= (RW+1)'(rt - t);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          r    <= (RW+1)'(rt);
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/rrl_div.sv
// ----------------------------------------------------------------------------
// rrl_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrl_div #(
  parameter int NW = 37,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic          running;
  logic [DW:0]   trial;

  // numerator bits leave at the top of quo while quotient bits enter below
  assign trial = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= num;
        dreg    <= den;
        rem     <= '0;
        cnt     <= CW'(NW);
        running <= 1'b1;
      end else if (running) begin
        if (trial >= {1'b0, dreg}) begin
          rem <= DW'(trial - {1'b0, dreg});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= DW'(trial);
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/radial_ripple_led_pattern.sv
// ----------------------------------------------------------------------------
// radial_ripple_led_pattern
// Expanding ring brightness pattern over a small LED grid.
// ----------------------------------------------------------------------------
// A restart transaction clears the ripple state and yields nothing. A frame
// transaction first runs a bit-serial radius division (36 quotient bits),
// unless the ripple has finished or the duration is zero, then walks the
// pixels one at a time: each pixel on the ring needs the serial square root
// (AW+8 root bits, 11 for an 8 wide grid), the serial intensity divider (20
// quotient bits) and the hand-off, multiply and output states; an output
// stall holds the frame in its emit state. Pixels off the ring skip the
// divider. Frames after the ripple has finished skip the arithmetic. The
// input is stalled while a frame is being worked on.
`default_nettype none

module radial_ripple_led_pattern #(
  parameter int GRID_WIDTH  = rrl_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = rrl_pkg::DEF_GRID_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [rrl_pkg::TIME_W-1:0]  now_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rrl_pkg::PIX_W-1:0]        led_index,
  output logic [rrl_pkg::LEVEL_W-1:0]      level,
  output logic                             last,
  input  wire logic                        cfg_we,
  input  wire logic [rrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rrl_pkg::DUR_W-1:0]   cfg_data
);

  import rrl_pkg::*;

  localparam int MAXWH = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
  localparam int AW    = $clog2(MAXWH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int RW    = AW + 8;
  localparam int SSW   = 2 * AW + 1;
  localparam int NPIX  = (GRID_WIDTH * GRID_HEIGHT > MAX_PIXELS) ?
                         MAX_PIXELS : GRID_WIDTH * GRID_HEIGHT;
  localparam int MAXD  = rrl_isqrt(longint'((GRID_WIDTH - 1) * (GRID_WIDTH - 1) +
                         (GRID_HEIGHT - 1) * (GRID_HEIGHT - 1)) << 14);
  localparam int RNW   = DUR_W + RW + 1;
  localparam int WQW   = 12;
  localparam int INW   = WQW + 8;
  localparam int DFW   = (RW + 1 > WQW) ? RW + 1 : WQW;

  localparam logic [RW:0]      TWO_MAXD = (RW + 1)'(2 * MAXD);
  localparam logic [AW:0]      WM1      = (AW + 1)'(GRID_WIDTH - 1);
  localparam logic [AW:0]      HM1      = (AW + 1)'(GRID_HEIGHT - 1);
  localparam logic [XW-1:0]    XLAST    = XW'(GRID_WIDTH - 1);
  localparam logic [PIX_W-1:0] LASTIDX  = PIX_W'(NPIX - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_RDIV, S_RWAIT, S_PIX, S_SQW, S_DIFF, S_IDIV, S_SQR,
    S_LVL, S_EMIT
  } state_t;

  state_t state;

  logic [DUR_W-1:0]  duration_us;
  logic [WWS_W-1:0]  wave_width_sixteenths;
  logic [PEAK_W-1:0] peak_level;

  logic              started;
  logic              finished;
  logic [TIME_W-1:0] origin_time;

  logic [DUR_W-1:0]   elap;
  logic [RNW-1:0]     prod;
  logic [RW:0]        radius;
  logic [RW-1:0]      pix_dist;
  logic [8:0]         inten;
  logic [9:0]         sq;
  logic [LEVEL_W-1:0] lvl;
  logic [XW-1:0]      x;
  logic [YW-1:0]      y;
  logic [PIX_W-1:0]   idx;

  // frame arrival
  logic [TIME_W-1:0] org;
  logic [TIME_W-1:0] elapsed;
  logic              fin_now;

  assign org     = started ? origin_time : now_us;
  assign elapsed = now_us - org;
  assign fin_now = finished || (elapsed > TIME_W'(duration_us));

  // pixel geometry in half-cell units
  logic [AW:0]       tx;
  logic [AW:0]       ty;
  logic [AW-1:0]     ax;
  logic [AW-1:0]     ay;
  logic [SSW-1:0]    sqsum;
  logic [2*RW-1:0]   sq_opnd;

  assign tx = (AW + 1)'({x, 1'b0});
  assign ty = (AW + 1)'({y, 1'b0});
  assign ax = (tx >= WM1) ? AW'(tx - WM1) : AW'(WM1 - tx);
  assign ay = (ty >= HM1) ? AW'(ty - HM1) : AW'(HM1 - ty);
  assign sqsum = SSW'(ax) * SSW'(ax) + SSW'(ay) * SSW'(ay);
  assign sq_opnd = (2 * RW)'({sqsum, 14'b0});

  logic [DFW-1:0] d_ext;
  logic [DFW-1:0] r_ext;
  logic [DFW-1:0] w_ext;
  logic [DFW-1:0] diff;
  logic           on_ring;
  logic [INW-1:0] inum;

  assign d_ext   = DFW'(pix_dist);
  assign r_ext   = DFW'(radius);
  assign w_ext   = DFW'({wave_width_sixteenths, 4'b0000});
  assign diff    = (d_ext > r_ext) ? d_ext - r_ext : r_ext - d_ext;
  assign on_ring = diff < w_ext;
  assign inum    = {WQW'(w_ext - diff), 8'b0};

  logic           sqrt_start;
  logic           sqrt_done;
  logic [RW-1:0]  sqrt_root;
  logic           rdiv_start;
  logic           rdiv_done;
  logic [RNW-1:0] rdiv_quo;
  logic           idiv_start;
  logic           idiv_done;
  logic [INW-1:0] idiv_quo;

  assign sqrt_start = (state == S_PIX) && !finished;
  assign rdiv_start = (state == S_RDIV);
  assign idiv_start = (state == S_DIFF) && on_ring;

  rrl_sqrt #(.RW(RW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .opnd  (sq_opnd),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  rrl_div #(.NW(RNW), .DW(DUR_W)) u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (rdiv_start),
    .num   (prod),
    .den   (duration_us),
    .done  (rdiv_done),
    .quo   (rdiv_quo)
  );

  rrl_div #(.NW(INW), .DW(WQW)) u_idiv (
    .clk   (clk),
    .rst   (rst),
    .start (idiv_start),
    .num   (inum),
    .den   (WQW'(w_ext)),
    .done  (idiv_done),
    .quo   (idiv_quo)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_us           <= RST_DURATION;
      wave_width_sixteenths <= RST_WAVE_W;
      peak_level            <= RST_PEAK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DURATION: duration_us           <= cfg_data;
        CFG_WAVE_W:   wave_width_sixteenths <= cfg_data[WWS_W-1:0];
        CFG_PEAK:     peak_level            <= cfg_data[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      started     <= 1'b0;
      finished    <= 1'b0;
      origin_time <= '0;
      out_valid   <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          x   <= '0;
          y   <= '0;
          idx <= '0;
          if (in_valid) begin
            if (kind) begin
              started  <= 1'b0;
              finished <= 1'b0;
            end else begin
              origin_time <= org;
              started     <= 1'b1;
              finished    <= fin_now;
              elap        <= elapsed[DUR_W-1:0];
              radius      <= '0;
              if (fin_now || duration_us == '0) begin
                state <= S_PIX;
              end else begin
                state <= S_PROD;
              end
            end
          end
        end
        S_PROD: begin
          prod  <= RNW'(elap) * RNW'(TWO_MAXD);
          state <= S_RDIV;
        end
        S_RDIV: state <= S_RWAIT;
        S_RWAIT: begin
          if (rdiv_done) begin
            radius <= rdiv_quo[RW:0];
            state  <= S_PIX;
          end
        end
        S_PIX: begin
          if (finished) begin
            lvl   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_SQW;
          end
        end
        S_SQW: begin
          if (sqrt_done) begin
            pix_dist <= sqrt_root;
            state    <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (on_ring) begin
            state <= S_IDIV;
          end else begin
            lvl   <= '0;
            state <= S_EMIT;
          end
        end
        S_IDIV: begin
          if (idiv_done) begin
            inten <= idiv_quo[8:0];
            state <= S_SQR;
          end
        end
        S_SQR: begin
          sq    <= 10'((18'(inten) * 18'(inten)) >> 8);
          state <= S_LVL;
        end
        S_LVL: begin
          lvl   <= LEVEL_W'((18'(sq) * 18'(peak_level)) >> 8);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            led_index <= idx;
            level     <= lvl;
            last      <= (idx == LASTIDX);
            if (idx == LASTIDX) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              if (x == XLAST) begin
                x <= '0;
                y <= y + 1'b1;
              end else begin
                x <= x + 1'b1;
              end
              state <= S_PIX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind) |=> (!started && !finished))
    else $error("restart did not clear ripple state");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (led_index == LASTIDX))
    else $error("last marked on wrong pixel");

  a_fin_started: assert property (@(posedge clk) disable iff (rst)
    finished |-> started)
    else $error("finished without a start time");

  a_radius_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> (radius <= TWO_MAXD))
    else $error("radius beyond twice the corner distance");

endmodule

`default_nettype wire

FILE: verif/radial_ripple_led_pattern_tb.sv
// ----------------------------------------------------------------------------
// radial_ripple_led_pattern_tb
// Self-checking bench: a scoreboard predicts every pixel of each frame from
// its own copy of the timing state and registers, and compares the block's
// output pixel by pixel under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_ripple_led_pattern_tb;
  import rrl_pkg::*;

  localparam int GW = DEF_GRID_WIDTH;
  localparam int GH = DEF_GRID_HEIGHT;
  localparam int NPIX = (GW * GH > MAX_PIXELS) ? MAX_PIXELS : GW * GH;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0]   idx;
    logic [LEVEL_W-1:0] lvl;
    logic               lst;
  } pixel_t;

  class ripple_scoreboard;
    pixel_t            expected_pixels[$];
    int                errors;
    logic [DUR_W-1:0]  duration;
    logic [WWS_W-1:0]  wave_w;
    logic [PEAK_W-1:0] peak;
    bit                started;
    bit                finished;
    logic [TIME_W-1:0] origin;

    function new();
      errors   = 0;
      duration = RST_DURATION;
      wave_w   = RST_WAVE_W;
      peak     = RST_PEAK;
      started  = 0;
      finished = 0;
      origin   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
      case (idx)
        CFG_DURATION: duration = data;
        CFG_WAVE_W:   wave_w = data[WWS_W-1:0];
        CFG_PEAK:     peak = data[PEAK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // q.8 distance from cell (x, y) to the exact grid center
    function longint unsigned center_dist(int x, int y);
      longint dx;
      longint dy;
      dx = (2 * x - (GW - 1)) * 128;
      dy = (2 * y - (GH - 1)) * 128;
      return floor_sqrt(dx * dx + dy * dy);
    endfunction

    function void note_accepted(logic k, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      longint unsigned radius, w, d, diff, inten, sq, maxd;
      pixel_t p;
      if (k) begin
        started  = 0;
        finished = 0;
        return;
      end
      if (!started) begin
        origin  = now;
        started = 1;
      end
      elapsed = now - origin;
      if (elapsed > duration) finished = 1;
      maxd   = center_dist(0, 0);
      radius = (duration != 0) ? (64'(elapsed) * 2 * maxd) / duration : 0;
      w      = 64'(wave_w) * 16;
      for (int i = 0; i < NPIX; i++) begin
        p.idx = i[PIX_W-1:0];
        p.lvl = '0;
        p.lst = (i == NPIX - 1);
        if (!finished && w != 0) begin
          d    = center_dist(i % GW, i / GW);
          diff = (d > radius) ? d - radius : radius - d;
          if (diff < w) begin
            inten = ((w - diff) * 256) / w;
            sq    = (inten * inten) >> 8;
            p.lvl = 8'((sq * peak) >> 8);
          end
        end
        expected_pixels.push_back(p);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel idx=%0d level=%0d last=%0b",
                 $time, got.idx, got.lvl, got.lst);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.idx !== want.idx) begin
        $display("%0t: led_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.lvl !== want.lvl) begin
        $display("%0t: level (pixel %0d) expected %0d actual %0d",
                 $time, want.idx, want.lvl, got.lvl);
        errors++;
      end
      if (got.lst !== want.lst) begin
        $display("%0t: last (pixel %0d) expected %0b actual %0b",
                 $time, want.idx, want.lst, got.lst);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic                 kind = 0;
  logic [TIME_W-1:0]    now_us = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  logic [PIX_W-1:0]     led_index;
  logic [LEVEL_W-1:0]   level;
  logic                 last;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data = '0;

  ripple_scoreboard sb = new();

  logic        hold_req = 0;
  logic        hold_seen = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_cnt = 0;

  radial_ripple_led_pattern i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .now_us(now_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_index(led_index), .level(level), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // accepted transactions on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_accepted(kind, now_us);
    if (!rst && out_valid && !out_stall) sb.check_pixel({led_index, level, last});
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 512 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 6000;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (mode_cnt % 7 < 2);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic send_item(logic k, logic [TIME_W-1:0] t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind     <= k;
    now_us   <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [DUR_W-1:0] dur, logic [WWS_W-1:0] ww,
                           logic [PEAK_W-1:0] pk);
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_WAVE_W, 24'(ww));
    write_reg(CFG_PEAK, 24'(pk));
    @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // one ripple: restart, then frames stepping through the duration
  task automatic run_ripple(int frames);
    logic [TIME_W-1:0] t;
    int span;
    span = (sb.duration / 6 > 0) ? sb.duration / 6 : 1;
    t = rand_time();
    send_item(1, rand_time());
    for (int i = 0; i < frames; i++) begin
      case ($urandom_range(0, 11))
        0:       send_item(0, rand_time());
        1:       send_item(1, rand_time());
        default: send_item(0, t);
      endcase
      t = t + TIME_W'($urandom_range(0, span));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, edges of the timeline
    send_item(0, '0);
    send_item(0, 48'd1500000);
    send_item(0, 48'd3000000);
    send_item(0, 48'd3000001);
    send_item(0, 48'd10);
    send_item(1, '0);
    send_item(1, TIME_MAX);
    send_item(0, TIME_MAX);
    send_item(0, 48'd5);
    send_item(1, '0);
    send_item(0, 48'd100);
    send_item(0, 48'd50);
    drain();

    configure(24'd1, 8'd255, 8'd255);
    send_item(1, '0);
    send_item(0, 48'h5555_5555_5555);
    send_item(0, 48'h5555_5555_5556);
    send_item(0, 48'h5555_5555_5557);
    drain();

    configure(24'hFFFFFF, 8'd1, 8'd0);
    send_item(1, '0);
    send_item(0, 48'hAAAA_AAAA_AAAA);
    send_item(0, 48'hAAAA_AAAA_AAAA + 48'h7FFFFF);
    drain();

    configure(24'd3000000, 8'd255, 8'd255);
    run_ripple(8);
    drain();

    // long receiver hold-off while frames keep coming
    hold_req <= ~hold_req;
    run_ripple(4);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      configure(DUR_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20)),
                WWS_W'($urandom_range(1, 255)), PEAK_W'($urandom_range(0, 255)));
      run_ripple(20);
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
